// ----- rtl/core/ide_tf_pkg.sv -----
// Package for the IDE task-file register block: constants, register offsets,
// command codes and the structs passed between the block's modules.
// Depends on nothing; every module of the block imports it.
package ide_tf_pkg;

   // Bytes of sector buffer given to each drive.
   localparam int unsigned BUFFER_BYTES = 512;
   localparam int unsigned POS_W        = $clog2(BUFFER_BYTES);
   localparam int unsigned ADDR_W       = $clog2(2 * BUFFER_BYTES);

   // Bus access kinds.
   localparam logic ACC_READ  = 1'b0;
   localparam logic ACC_WRITE = 1'b1;

   // Task-file register offsets.
   localparam logic [2:0] REG_DATA     = 3'd0;
   localparam logic [2:0] REG_ERROR    = 3'd1;
   localparam logic [2:0] REG_COUNT    = 3'd2;
   localparam logic [2:0] REG_SECTOR   = 3'd3;
   localparam logic [2:0] REG_CYL_LO   = 3'd4;
   localparam logic [2:0] REG_CYL_HI   = 3'd5;
   localparam logic [2:0] REG_DRV_HEAD = 3'd6;
   localparam logic [2:0] REG_COMMAND  = 3'd7;

   // Command codes.
   localparam logic [7:0] CMD_RECAL_LO = 8'h10;
   localparam logic [7:0] CMD_RECAL_HI = 8'h1f;
   localparam logic [7:0] CMD_READ     = 8'h20;
   localparam logic [7:0] CMD_READ_NR  = 8'h21;
   localparam logic [7:0] CMD_WRITE    = 8'h30;
   localparam logic [7:0] CMD_WRITE_NR = 8'h31;

   // Fixed upper bits of the drive/head register as read back.
   localparam logic [2:0] DH_TOP_LBA = 3'b111;
   localparam logic [2:0] DH_TOP_CHS = 3'b101;

   // Value a data-port read returns when no transfer is pending.
   localparam logic [7:0] EMPTY_DATA = 8'hff;

   // Access to the sector buffer memory.
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wdata;
   } buf_req_type;

   // Read result of one beat: either a register value or the buffer's byte.
   typedef struct packed {
      logic       from_buffer;
      logic [7:0] value;
   } rd_result_type;

endpackage

// ----- rtl/core/ide_task_file_register_block.sv -----
// IDE task-file register block for a master and a slave drive.
// Each req_ beat is one 8-bit bus access (req_command: 0 read, 1 write) at
// task-file offset req_reg_offset 0..7; each access gives exactly one rsp_
// beat carrying rsp_read_data (the byte read, or zero for a write).
// The drive/head register picks the drive and its CHS or LBA addressing;
// transfer commands load a byte count of sector count times 512 and the data
// port then moves one byte per access through the drive's own sector buffer.
// A taken access passes through stage one (register update and registered
// buffer read) and then the output register. One access per cycle is taken
// while the receiver takes responses; the single-port buffer memory serves
// one byte in each cycle.
// The pipeline holds two beats, so req_ready stays high while one response
// waits on a stalled receiver; it drops only when both stages are full.
// Reset clears all task-file registers and counts and empties the pipeline;
// the buffer contents are undefined until written and need no clearing.
// Depends on ide_tf_pkg, ide_tf_regs and ide_tf_buffer.
module ide_task_file_register_block (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_command,
   input  logic [2:0] req_reg_offset,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data
);
   import ide_tf_pkg::*;

   buf_req_type   buf_req;
   rd_result_type rd_result;
   logic [7:0]    buf_rd_data_ff;

   logic          accept;
   logic          advance;
   logic          s1_valid_ff, s1_valid_in;
   rd_result_type s1_result_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_read_data_ff, rsp_read_data_in;

   // Handshake of the two stages.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   ide_tf_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .command    (req_command),
      .reg_offset (req_reg_offset),
      .write_data (req_write_data),
      .buf_req    (buf_req),
      .rd_result  (rd_result)
   );

   ide_tf_buffer u_buffer (
      .clock      (clock),
      .buf_req    (buf_req),
      .rd_data_ff (buf_rd_data_ff)
   );

   // Stage one: the beat's read-back selection, alongside the buffer read.
   assign s1_valid_in = accept || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_result_ff <= rd_result;
      end
   end

   // Output register.
   assign rsp_valid_in     = advance || (rsp_valid_ff && !rsp_ready);
   assign rsp_read_data_in = s1_result_ff.from_buffer ? buf_rd_data_ff : s1_result_ff.value;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_read_data_ff <= rsp_read_data_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;

   // An empty first stage always takes a beat.
   assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("request stalled with stage one empty");

   // A taken beat occupies stage one in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted beat lost before stage one");

   // A beat in stage one stays there while the output is blocked.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |=> (s1_valid_ff && $stable(s1_result_ff)))
      else $error("stage one beat dropped during stall");

   // The buffer never reads and writes in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({buf_req.rd_en, buf_req.wr_en}))
      else $error("buffer read and write in one cycle");

endmodule

// ----- rtl/core/ide_tf_buffer.sv -----
// Sector buffer memory for both drives, one port, registered read data.
// Depends on ide_tf_pkg for the access struct and depth.
module ide_tf_buffer (
   input  logic                      clock,
   input  ide_tf_pkg::buf_req_type   buf_req,
   output logic [7:0]                rd_data_ff
);
   import ide_tf_pkg::*;

   logic [7:0] buffer_mem [2 * BUFFER_BYTES];

   // One access per cycle: a write or a read, never both.
   always_ff @(posedge clock) begin
      if (buf_req.wr_en) begin
         buffer_mem[buf_req.addr] <= buf_req.wdata;
      end
      if (buf_req.rd_en) begin
         rd_data_ff <= buffer_mem[buf_req.addr];
      end
   end

endmodule

// ----- rtl/core/ide_tf_regs.sv -----
// Task-file registers of both drives, access decode and read-back selection.
// Depends on ide_tf_pkg; drives the sector buffer through a buf_req_type.
module ide_tf_regs (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        command,
   input  logic [2:0]                  reg_offset,
   input  logic [7:0]                  write_data,
   output ide_tf_pkg::buf_req_type     buf_req,
   output ide_tf_pkg::rd_result_type   rd_result
);
   import ide_tf_pkg::*;

   logic              selected_drive_ff, selected_drive_in;
   logic              lba_mode_ff  [2];
   logic              lba_mode_in  [2];
   logic [15:0]       cylinder_ff  [2];
   logic [15:0]       cylinder_in  [2];
   logic [3:0]        head_ff      [2];
   logic [3:0]        head_in      [2];
   logic [27:0]       block_ff     [2];
   logic [27:0]       block_in     [2];
   logic [7:0]        count_ff     [2];
   logic [7:0]        count_in     [2];
   logic [16:0]       left_ff      [2];
   logic [16:0]       left_in      [2];
   logic [POS_W-1:0]  pos_ff       [2];
   logic [POS_W-1:0]  pos_in       [2];

   logic              drv;
   logic              new_drv;
   logic              xfer_live;
   logic [POS_W-1:0]  pos_next;
   logic [ADDR_W-1:0] buf_addr;

   assign drv       = selected_drive_ff;
   assign new_drv   = write_data[4];
   assign xfer_live = (left_ff[drv] != 17'd0);

   // Buffer pointer advance with wrap, and the drive's offset into the memory.
   assign pos_next = (pos_ff[drv] == POS_W'(BUFFER_BYTES - 1)) ? '0 : pos_ff[drv] + 1'b1;
   assign buf_addr = drv ? ADDR_W'(BUFFER_BYTES) + ADDR_W'(pos_ff[drv])
                         : ADDR_W'(pos_ff[drv]);

   // Data port access to the buffer.
   always_comb begin
      buf_req.addr  = buf_addr;
      buf_req.wdata = write_data;
      buf_req.wr_en = accept && (reg_offset == REG_DATA) && (command == ACC_WRITE) && xfer_live;
      buf_req.rd_en = accept && (reg_offset == REG_DATA) && (command == ACC_READ) && xfer_live;
   end

   // Read-back value for the current beat.
   always_comb begin
      rd_result.from_buffer = 1'b0;
      rd_result.value       = 8'd0;
      if (command == ACC_READ) begin
         case (reg_offset)
            REG_DATA: begin
               if (xfer_live) begin
                  rd_result.from_buffer = 1'b1;
               end else begin
                  rd_result.value = EMPTY_DATA;
               end
            end
            REG_COUNT: begin
               rd_result.value = count_ff[drv];
            end
            REG_SECTOR: begin
               rd_result.value = block_ff[drv][7:0];
            end
            REG_CYL_LO: begin
               rd_result.value = lba_mode_ff[drv] ? block_ff[drv][15:8] : cylinder_ff[drv][7:0];
            end
            REG_CYL_HI: begin
               rd_result.value = lba_mode_ff[drv] ? block_ff[drv][23:16]
                                                  : cylinder_ff[drv][15:8];
            end
            REG_DRV_HEAD: begin
               rd_result.value = lba_mode_ff[drv] ? {DH_TOP_LBA, drv, block_ff[drv][27:24]}
                                                  : {DH_TOP_CHS, drv, head_ff[drv]};
            end
            default: begin
               rd_result.value = 8'd0;
            end
         endcase
      end
   end

   // Next state of the register file.
   always_comb begin
      selected_drive_in = selected_drive_ff;
      for (int i = 0; i < 2; i++) begin
         lba_mode_in[i] = lba_mode_ff[i];
         cylinder_in[i] = cylinder_ff[i];
         head_in[i]     = head_ff[i];
         block_in[i]    = block_ff[i];
         count_in[i]    = count_ff[i];
         left_in[i]     = left_ff[i];
         pos_in[i]      = pos_ff[i];
      end
      if (accept) begin
         // A data-port beat in either direction advances a live transfer.
         if ((reg_offset == REG_DATA) && xfer_live) begin
            pos_in[drv]  = pos_next;
            left_in[drv] = left_ff[drv] - 17'd1;
         end
         if (command == ACC_WRITE) begin
            case (reg_offset)
               REG_COUNT: begin
                  count_in[drv] = write_data;
               end
               REG_SECTOR: begin
                  if (lba_mode_ff[drv]) begin
                     block_in[drv][7:0] = write_data;
                  end else begin
                     block_in[drv] = {20'd0, write_data};
                  end
               end
               REG_CYL_LO: begin
                  if (lba_mode_ff[drv]) begin
                     block_in[drv][15:8] = write_data;
                  end else begin
                     cylinder_in[drv][7:0] = write_data;
                  end
               end
               REG_CYL_HI: begin
                  if (lba_mode_ff[drv]) begin
                     block_in[drv][23:16] = write_data;
                  end else begin
                     cylinder_in[drv][15:8] = write_data;
                  end
               end
               REG_DRV_HEAD: begin
                  // The write picks the drive and then sets that drive's mode.
                  selected_drive_in    = new_drv;
                  lba_mode_in[new_drv] = write_data[6];
                  if (write_data[6]) begin
                     block_in[new_drv][27:24] = write_data[3:0];
                  end else begin
                     head_in[new_drv] = write_data[3:0];
                  end
               end
               REG_COMMAND: begin
                  if (write_data inside {[CMD_RECAL_LO:CMD_RECAL_HI]}) begin
                     cylinder_in[drv] = 16'd0;
                  end else if (write_data inside {CMD_READ, CMD_READ_NR,
                                                  CMD_WRITE, CMD_WRITE_NR}) begin
                     pos_in[drv]  = '0;
                     left_in[drv] = {count_ff[drv], 9'd0};
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // State registers; everything clears at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         selected_drive_ff <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            lba_mode_ff[i] <= 1'b0;
            cylinder_ff[i] <= 16'd0;
            head_ff[i]     <= 4'd0;
            block_ff[i]    <= 28'd0;
            count_ff[i]    <= 8'd0;
            left_ff[i]     <= 17'd0;
            pos_ff[i]      <= '0;
         end
      end else begin
         selected_drive_ff <= selected_drive_in;
         for (int i = 0; i < 2; i++) begin
            lba_mode_ff[i] <= lba_mode_in[i];
            cylinder_ff[i] <= cylinder_in[i];
            head_ff[i]     <= head_in[i];
            block_ff[i]    <= block_in[i];
            count_ff[i]    <= count_in[i];
            left_ff[i]     <= left_in[i];
            pos_ff[i]      <= pos_in[i];
         end
      end
   end

   // A buffer access happens only while a transfer is live.
   assert property (@(posedge clock) disable iff (reset)
      (buf_req.wr_en || buf_req.rd_en) |-> xfer_live)
      else $error("buffer accessed with no transfer pending");

   // A buffer access consumes exactly one byte of the count.
   assert property (@(posedge clock) disable iff (reset)
      (buf_req.wr_en || buf_req.rd_en) |=> (left_ff[$past(drv)] == $past(left_ff[drv]) - 17'd1))
      else $error("byte count did not step on a buffer access");

   // A beat from the buffer is always a read.
   assert property (@(posedge clock) disable iff (reset)
      (accept && rd_result.from_buffer) |-> buf_req.rd_en)
      else $error("buffer result without a buffer read");

endmodule

// ----- tb/tb_ide_task_file_register_block.sv -----
// Self-checking testbench for the IDE task-file register block: a directed
// table of bus accesses followed by random transfer and register sequences.
// Depends on ide_tf_pkg and the ide_task_file_register_block RTL.
`timescale 1ns / 100ps

module tb_ide_task_file_register_block;
   import ide_tf_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 8;
   localparam int ITEMS_TARGET = 1300;
   localparam int DRAIN_CYCLES = 16;
   localparam int MAX_REPORTS  = 50;
   localparam int TIMEOUT_NS   = 10_000_000;

   // A command byte that this block does not decode.
   localparam logic [7:0] CMD_IDENTIFY = 8'hec;

   // Row kinds of the directed table: result typed in, or taken from the predictor.
   localparam logic KNOWN   = 1'b1;
   localparam logic PREDICT = 1'b0;

   typedef struct packed {
      logic       command;
      logic [2:0] reg_offset;
      logic [7:0] write_data;
      logic       known;
      logic [7:0] known_data;
   } access_row_type;

   typedef struct packed {
      logic [31:0] index;
      logic [7:0]  data;
   } read_expect_type;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic       req_command    = 1'b0;
   logic [2:0] req_reg_offset = 3'd0;
   logic [7:0] req_write_data = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic [7:0] rsp_read_data;

   // Predicted task-file state, one copy per drive.
   logic        cur_drive;
   logic        lba_on       [0:1];
   logic [15:0] cylinder     [0:1];
   logic [3:0]  head_no      [0:1];
   logic [27:0] block_addr   [0:1];
   logic [7:0]  sect_count   [0:1];
   logic [16:0] bytes_due    [0:1];
   int unsigned buf_pos      [0:1];
   logic [7:0]  sector_bytes [0:1][0:BUFFER_BYTES-1];
   bit          byte_written [0:1][0:BUFFER_BYTES-1];

   read_expect_type expected_read_data [$];
   int unsigned  items_sent;
   int unsigned  mismatches;
   int           tx_mode;
   int           tx_left;
   bit           wrap_seen;

   access_row_type directed_rows [29] = '{
      '{ACC_READ,  REG_DRV_HEAD, 8'h00,        KNOWN,   8'ha0},
      '{ACC_READ,  REG_DATA,     8'h00,        KNOWN,   EMPTY_DATA},
      '{ACC_READ,  REG_COMMAND,  8'hff,        KNOWN,   8'h00},
      '{ACC_WRITE, REG_ERROR,    8'hff,        KNOWN,   8'h00},
      '{ACC_READ,  REG_ERROR,    8'h00,        KNOWN,   8'h00},
      '{ACC_WRITE, REG_COUNT,    8'hff,        KNOWN,   8'h00},
      '{ACC_READ,  REG_COUNT,    8'h00,        KNOWN,   8'hff},
      '{ACC_WRITE, REG_CYL_HI,   8'hff,        KNOWN,   8'h00},
      '{ACC_WRITE, REG_COMMAND,  CMD_RECAL_LO, KNOWN,   8'h00},
      '{ACC_READ,  REG_CYL_HI,   8'h00,        KNOWN,   8'h00},
      '{ACC_WRITE, REG_DRV_HEAD, 8'hff,        KNOWN,   8'h00},
      '{ACC_READ,  REG_DRV_HEAD, 8'h00,        KNOWN,   8'hff},
      '{ACC_WRITE, REG_CYL_LO,   8'hff,        KNOWN,   8'h00},
      '{ACC_WRITE, REG_DRV_HEAD, 8'hbf,        KNOWN,   8'h00},
      '{ACC_WRITE, REG_SECTOR,   8'h00,        KNOWN,   8'h00},
      '{ACC_WRITE, REG_DRV_HEAD, 8'hf0,        KNOWN,   8'h00},
      '{ACC_READ,  REG_CYL_LO,   8'h00,        PREDICT, 8'h00},
      '{ACC_WRITE, REG_COMMAND,  CMD_READ,     KNOWN,   8'h00},
      '{ACC_WRITE, REG_DATA,     8'h5a,        KNOWN,   8'h00},
      '{ACC_READ,  REG_DATA,     8'h00,        KNOWN,   EMPTY_DATA},
      '{ACC_WRITE, REG_DRV_HEAD, 8'h00,        KNOWN,   8'h00},
      '{ACC_WRITE, REG_COMMAND,  CMD_WRITE_NR, KNOWN,   8'h00},
      '{ACC_WRITE, REG_DATA,     8'hff,        KNOWN,   8'h00},
      '{ACC_WRITE, REG_DATA,     8'h00,        KNOWN,   8'h00},
      '{ACC_WRITE, REG_COMMAND,  CMD_READ_NR,  KNOWN,   8'h00},
      '{ACC_WRITE, REG_COMMAND,  CMD_IDENTIFY, KNOWN,   8'h00},
      '{ACC_READ,  REG_DATA,     8'h00,        PREDICT, 8'h00},
      '{ACC_READ,  REG_DATA,     8'h00,        PREDICT, 8'h00},
      '{ACC_WRITE, REG_COMMAND,  CMD_WRITE,    KNOWN,   8'h00}
   };

   ide_task_file_register_block u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_reg_offset (req_reg_offset),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Idle cycles before the next beat. Each side runs in stretches of no idling,
   // occasional idling or heavy idling, re-chosen every few dozen beats.
   function automatic int pick_wait(inout int mode, inout int left);
      if (left == 0) begin
         mode = $urandom_range(0, 2);
         left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
         0: return 0;
         1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 17)) : 0;
         default: return $urandom_range(0, 17);
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t ns: mismatch: %s", $time, msg);
   endtask

   // Clears the predicted state as reset does; buffer bytes become unwritten.
   function automatic void clear_task_file();
      cur_drive = 1'b0;
      for (int d = 0; d < 2; d++) begin
         lba_on[d]     = 1'b0;
         cylinder[d]   = '0;
         head_no[d]    = '0;
         block_addr[d] = '0;
         sect_count[d] = '0;
         bytes_due[d]  = '0;
         buf_pos[d]    = 0;
         for (int i = 0; i < BUFFER_BYTES; i++)
            byte_written[d][i] = 1'b0;
      end
   endfunction

   // Applies one bus access to the predicted state and returns the byte read.
   function automatic logic [7:0] task_file_access(input logic cmd, input logic [2:0] off,
                                                   input logic [7:0] wd);
      logic       d;
      logic [7:0] rd;
      d  = cur_drive;
      rd = 8'h00;
      if (cmd == ACC_WRITE) begin
         case (off)
            REG_DATA: if (bytes_due[d] != 0) begin
               sector_bytes[d][buf_pos[d]] = wd;
               byte_written[d][buf_pos[d]] = 1'b1;
               buf_pos[d]   = (buf_pos[d] + 1) % BUFFER_BYTES;
               bytes_due[d] = bytes_due[d] - 1'b1;
            end
            REG_COUNT: sect_count[d] = wd;
            // A CHS sector number replaces the whole address, not just its low byte.
            REG_SECTOR: if (lba_on[d]) block_addr[d][7:0] = wd;
                        else block_addr[d] = {20'h0, wd};
            REG_CYL_LO: if (lba_on[d]) block_addr[d][15:8] = wd;
                        else cylinder[d][7:0] = wd;
            REG_CYL_HI: if (lba_on[d]) block_addr[d][23:16] = wd;
                        else cylinder[d][15:8] = wd;
            REG_DRV_HEAD: begin
               cur_drive = wd[4];
               d         = wd[4];
               lba_on[d] = wd[6];
               if (lba_on[d]) block_addr[d][27:24] = wd[3:0];
               else head_no[d] = wd[3:0];
            end
            REG_COMMAND:
               if (wd >= CMD_RECAL_LO && wd <= CMD_RECAL_HI) begin
                  cylinder[d] = '0;
               end else if (wd == CMD_READ || wd == CMD_READ_NR ||
                            wd == CMD_WRITE || wd == CMD_WRITE_NR) begin
                  buf_pos[d]   = 0;
                  bytes_due[d] = {sect_count[d], 9'h000};
               end
            default: ;
         endcase
      end else begin
         case (off)
            REG_DATA: if (bytes_due[d] == 0) begin
               rd = EMPTY_DATA;
            end else begin
               rd           = sector_bytes[d][buf_pos[d]];
               buf_pos[d]   = (buf_pos[d] + 1) % BUFFER_BYTES;
               bytes_due[d] = bytes_due[d] - 1'b1;
            end
            REG_COUNT:  rd = sect_count[d];
            REG_SECTOR: rd = block_addr[d][7:0];
            REG_CYL_LO: rd = lba_on[d] ? block_addr[d][15:8] : cylinder[d][7:0];
            REG_CYL_HI: rd = lba_on[d] ? block_addr[d][23:16] : cylinder[d][15:8];
            REG_DRV_HEAD:
               rd = lba_on[d] ? {DH_TOP_LBA, d, block_addr[d][27:24]}
                              : {DH_TOP_CHS, d, head_no[d]};
            default: rd = 8'h00;
         endcase
      end
      return rd;
   endfunction

   // Drives one access beat, waits for it to be taken and queues its read data.
   // A data read that would land on a never-written buffer byte becomes a write.
   task automatic send_access(input logic cmd, input logic [2:0] off, input logic [7:0] wd,
                              input logic known = PREDICT, input logic [7:0] known_data = 8'h00);
      int         gap;
      logic [7:0] predicted;
      read_expect_type entry;
      if (cmd == ACC_READ && off == REG_DATA && bytes_due[cur_drive] != 0 &&
          !byte_written[cur_drive][buf_pos[cur_drive]])
         cmd = ACC_WRITE;
      gap = pick_wait(tx_mode, tx_left);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_reg_offset <= off;
      req_write_data <= wd;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted  = task_file_access(cmd, off, wd);
      entry.index = items_sent;
      entry.data  = (known == KNOWN) ? known_data : predicted;
      expected_read_data.push_back(entry);
      items_sent++;
   endtask

   // A transfer: select a drive, load a count, issue a write command, stream
   // data in, then rewind with a read command and stream it back out.
   task automatic run_transfer();
      logic [7:0] count_byte;
      bit         long_run;
      int         n_write;
      int         n_read;
      long_run = !wrap_seen ||
                 ($urandom_range(0, 15) == 0 && items_sent + 1200 < ITEMS_TARGET);
      send_access(ACC_WRITE, REG_DRV_HEAD, 8'($urandom));
      case ($urandom_range(0, 9))
         0:       count_byte = 8'h00;
         1:       count_byte = 8'hff;
         default: count_byte = 8'($urandom_range(1, 2));
      endcase
      if (long_run)
         count_byte = 8'($urandom_range(2, 3));
      send_access(ACC_WRITE, REG_COUNT, count_byte);
      send_access(ACC_WRITE, REG_COMMAND, $urandom_range(0, 1) ? CMD_WRITE : CMD_WRITE_NR);
      // Long runs can pass the end of the buffer so that the pointer wraps.
      n_write = long_run ? $urandom_range(500, 560) : $urandom_range(1, 40);
      wrap_seen = 1'b1;
      for (int i = 0; i < n_write; i++) begin
         if ($urandom_range(0, 11) == 0)
            send_access(ACC_READ, 3'($urandom_range(REG_ERROR, REG_COMMAND)),
                        8'($urandom));
         send_access(ACC_WRITE, REG_DATA, 8'($urandom));
      end
      send_access(ACC_WRITE, REG_COMMAND, $urandom_range(0, 1) ? CMD_READ : CMD_READ_NR);
      n_read = $urandom_range(1, n_write + 4);
      for (int i = 0; i < n_read; i++)
         send_access(ACC_READ, REG_DATA, 8'($urandom));
   endtask

   // Address set-up in either mode, sometimes a recalibrate or a mode change,
   // then every readable register read back.
   task automatic run_address_setup();
      send_access(ACC_WRITE, REG_DRV_HEAD, 8'($urandom));
      send_access(ACC_WRITE, REG_SECTOR, 8'($urandom));
      send_access(ACC_WRITE, REG_CYL_LO, 8'($urandom));
      send_access(ACC_WRITE, REG_CYL_HI, 8'($urandom));
      if ($urandom_range(0, 2) == 0)
         send_access(ACC_WRITE, REG_COMMAND,
                     8'($urandom_range(CMD_RECAL_LO, CMD_RECAL_HI)));
      if ($urandom_range(0, 2) == 0)
         send_access(ACC_WRITE, REG_DRV_HEAD, 8'($urandom));
      for (int off = REG_DATA; off <= REG_COMMAND; off++)
         send_access(ACC_READ, off[2:0], 8'($urandom));
   endtask

   // Stimulus: reset, the directed table, random sequences, then the drain.
   initial begin : stimulus
      int kind;
      clear_task_file();
      items_sent = 0;
      mismatches = 0;
      tx_mode    = 0;
      tx_left    = 0;
      wrap_seen  = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_access(directed_rows[i].command, directed_rows[i].reg_offset,
                     directed_rows[i].write_data, directed_rows[i].known,
                     directed_rows[i].known_data);

      while (items_sent < ITEMS_TARGET) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            run_transfer();
         end else if (kind <= 7) begin
            run_address_setup();
         end else begin
            repeat ($urandom_range(1, 8))
               send_access(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                           8'($urandom));
         end
      end
      req_valid <= 1'b0;

      while (expected_read_data.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_read_data.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Receiver: stalls at random before each beat, otherwise holds ready high.
   initial begin : receiver
      int stall;
      int rx_mode;
      int rx_left;
      rx_mode = 0;
      rx_left = 0;
      forever begin
         stall = pick_wait(rx_mode, rx_left);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // Each response beat is checked against the oldest outstanding access.
   always @(posedge clock) begin : check_response
      read_expect_type oldest;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_read_data.size() == 0) begin
            report_mismatch($sformatf("response %02h with no access outstanding",
                                      rsp_read_data));
         end else begin
            oldest = expected_read_data.pop_front();
            if (rsp_read_data !== oldest.data)
               report_mismatch($sformatf("access %0d: read_data %02h, expected %02h",
                                         oldest.index, rsp_read_data, oldest.data));
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("TEST FAILED");
      $finish;
   end

endmodule
